// File: src/dcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcp_pkg
// Shared types and constants for the intra DC prediction and reconstruction
// block.
// ----------------------------------------------------------------------------
package dcp_pkg;

   localparam int MAX_BAND_WIDTH = 1024;
   localparam int COEFF_BITS     = 16;
   localparam int COL_BITS       = $clog2(MAX_BAND_WIDTH);
   localparam int WIDTH_BITS     = 11;

   localparam logic [WIDTH_BITS-1:0] BAND_WIDTH_RESET = WIDTH_BITS'(64);
   localparam logic [WIDTH_BITS-1:0] BAND_WIDTH_MAX   = WIDTH_BITS'(MAX_BAND_WIDTH);
   localparam logic [WIDTH_BITS-1:0] BAND_WIDTH_MIN   = WIDTH_BITS'(1);

   // Three-neighbor sum is biased positive, then divided by 3 with a
   // reciprocal multiply. The bias is a multiple of 3, so the floor carries.
   localparam int SUM_BITS   = COEFF_BITS + 2;
   localparam int SUM_BIAS   = 3 * (1 << (COEFF_BITS - 1)) * 2;
   localparam int DIV3_SHIFT = SUM_BITS + 1;
   localparam int DIV3_MULT  = ((1 << DIV3_SHIFT) + 2) / 3;
   localparam int PROD_BITS  = 2 * SUM_BITS;

   typedef struct packed {
      logic signed [COEFF_BITS-1:0] residual_in;
      logic                         skipped;
      logic                         band_start;
   } req_type;

   typedef struct packed {
      logic signed [COEFF_BITS-1:0] reconstructed;
      logic signed [COEFF_BITS-1:0] prediction_out;
      logic                         neighbourhood_nonzero;
      logic                         row_end;
   } rsp_type;

   // position of one coefficient in the band
   typedef struct packed {
      logic [COL_BITS-1:0] col;
      logic                first_row;
      logic                row_end;
   } pos_type;

   // one line store entry
   typedef struct packed {
      logic signed [COEFF_BITS-1:0] value;
      logic                         nonzero;
   } line_type;

endpackage : dcp_pkg
`default_nettype wire

// File: src/intra_dc_predict_reconstruct.sv
`default_nettype none
// ----------------------------------------------------------------------------
// intra_dc_predict_reconstruct
// Decoder-side DC band reconstruction with neighbor prediction.
// ----------------------------------------------------------------------------
// Takes one coefficient per clock and gives one result per clock when the
// result side does not stall. A result is in the output register once its
// transaction leaves the first stage: the accepting edge also registers the
// read of the row above from the 1024 x 17 line store, and the first stage
// forms the prediction, the saturated sum and the context flag. The
// left-neighbor loop (three-term add, multiply by the reciprocal of 3,
// residual add) lies within the first stage. The line store has no
// reset and no clearing pass: it is ready right after reset, and a column
// that has never been written in the current band width reads as an
// arbitrary value. The user must write band_width only while the block is
// idle; the block does not enforce it. csr_ready is high whenever reset is low.
// ----------------------------------------------------------------------------
module intra_dc_predict_reconstruct
   import dcp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [WIDTH_BITS-1:0] csr_data
);

   logic     s1_valid_ff;
   logic     s1_valid_in;
   req_type  s1_item_ff;
   pos_type  s1_pos_ff;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   rsp_type  rsp_data_ff;

   logic     out_free;
   logic     advance;
   logic     accept;
   logic     csr_write;
   pos_type  pos;
   line_type up_entry;
   line_type wr_entry;
   rsp_type  rsp_next;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = reset || (s1_valid_ff && !out_free);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = !reset;
   assign csr_write = csr_valid && csr_ready;

   dcp_position u_position (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_data   (csr_data),
      .accept     (accept),
      .band_start (req_data.band_start),
      .pos        (pos)
   );

   dcp_line_store u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (pos.col),
      .wr_en   (advance),
      .wr_addr (s1_pos_ff.col),
      .wr_data (wr_entry),
      .rd_data (up_entry)
   );

   dcp_predictor u_predictor (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .item     (s1_item_ff),
      .pos      (s1_pos_ff),
      .up       (up_entry),
      .rsp      (rsp_next),
      .wr_entry (wr_entry)
   );

   always_comb begin
      s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_data;
         s1_pos_ff  <= pos;
      end
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with an empty first stage");

   a_band_start_origin: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.band_start) |=> (s1_pos_ff.col == '0 && s1_pos_ff.first_row))
      else $error("band start did not restart at the origin");

   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_valid_ff && rsp_data_ff == $past(rsp_next)))
      else $error("finished item did not reach the output register");

   a_row_end_wraps: assert property (@(posedge clock) disable iff (reset)
      (accept && pos.row_end && !req_data.band_start) ##1 (accept && !req_data.band_start)
      |-> (pos.col == '0 && !pos.first_row))
      else $error("row end did not wrap to column zero of the next row");
`endif

endmodule : intra_dc_predict_reconstruct
`default_nettype wire

// File: src/dcp_position.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcp_position
// Band width register and raster position tracking (column, first row,
// row end) for each accepted coefficient.
// ----------------------------------------------------------------------------
module dcp_position
   import dcp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [WIDTH_BITS-1:0] csr_data,
   input  wire logic                  accept,
   input  wire logic                  band_start,
   output pos_type                    pos
);

   logic [WIDTH_BITS-1:0] band_width_ff;
   logic [WIDTH_BITS-1:0] band_width_in;
   logic [COL_BITS-1:0]   column_count_ff;
   logic [COL_BITS-1:0]   column_count_in;
   logic                  on_first_row_ff;
   logic                  on_first_row_in;
   logic [WIDTH_BITS-1:0] width_eff;
   logic [WIDTH_BITS-1:0] col_next;

   always_comb begin
      if (band_width_ff == '0) begin
         width_eff = BAND_WIDTH_MIN;
      end else if (band_width_ff > BAND_WIDTH_MAX) begin
         width_eff = BAND_WIDTH_MAX;
      end else begin
         width_eff = band_width_ff;
      end
   end

   always_comb begin
      pos.col       = band_start ? '0 : column_count_ff;
      pos.first_row = band_start | on_first_row_ff;
      col_next      = {1'b0, pos.col} + BAND_WIDTH_MIN;
      pos.row_end   = (col_next >= width_eff);
   end

   always_comb begin
      band_width_in   = csr_write ? csr_data : band_width_ff;
      column_count_in = column_count_ff;
      on_first_row_in = on_first_row_ff;
      if (accept) begin
         column_count_in = pos.row_end ? '0 : col_next[COL_BITS-1:0];
         on_first_row_in = pos.row_end ? 1'b0 : pos.first_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         band_width_ff   <= BAND_WIDTH_RESET;
         column_count_ff <= '0;
         on_first_row_ff <= 1'b1;
      end else begin
         band_width_ff   <= band_width_in;
         column_count_ff <= column_count_in;
         on_first_row_ff <= on_first_row_in;
      end
   end

endmodule : dcp_position
`default_nettype wire

// File: src/dcp_line_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcp_line_store
// Line store of the row above: reconstructed value and residual nonzero bit
// per column. Registered read with forwarding of a same-cycle write.
// ----------------------------------------------------------------------------
module dcp_line_store
   import dcp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                rd_en,
   input  wire logic [COL_BITS-1:0] rd_addr,
   input  wire logic                wr_en,
   input  wire logic [COL_BITS-1:0] wr_addr,
   input  wire line_type            wr_data,
   output line_type                 rd_data
);

   line_type line_mem_ff [MAX_BAND_WIDTH];
   line_type mem_q_ff;
   line_type byp_data_ff;
   logic     byp_ff;
   logic     byp_in;

   assign byp_in = rd_en ? (wr_en && (wr_addr == rd_addr)) : byp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff    <= line_mem_ff[rd_addr];
         byp_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= byp_in;
      end
   end

   // a write landing in the read cycle is not yet in the array
   assign rd_data = byp_ff ? byp_data_ff : mem_q_ff;

endmodule : dcp_line_store
`default_nettype wire

// File: src/dcp_predictor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcp_predictor
// Neighbor prediction, residual add with saturation and context flag.
// Holds the left and upper-left neighbor state.
// ----------------------------------------------------------------------------
module dcp_predictor
   import dcp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     advance,
   input  wire req_type  item,
   input  wire pos_type  pos,
   input  wire line_type up,
   output rsp_type       rsp,
   output line_type      wr_entry
);

   logic signed [COEFF_BITS-1:0] left_value_ff;
   logic signed [COEFF_BITS-1:0] left_value_in;
   logic signed [COEFF_BITS-1:0] upleft_value_ff;
   logic signed [COEFF_BITS-1:0] upleft_value_in;
   logic                         left_nz_ff;
   logic                         left_nz_in;
   logic                         upleft_nz_ff;
   logic                         upleft_nz_in;

   logic signed [SUM_BITS:0]     sum;
   logic [SUM_BITS-1:0]          biased;
   logic [PROD_BITS-1:0]         prod;
   logic [COEFF_BITS-1:0]        quot;
   logic signed [COEFF_BITS-1:0] pred_avg;
   logic signed [COEFF_BITS-1:0] pred;
   logic signed [COEFF_BITS-1:0] resid;
   logic signed [COEFF_BITS:0]   total;
   logic signed [COEFF_BITS-1:0] rec;
   logic                         nz;
   logic                         not_col0;

   // floor((left + upleft + up + 1) / 3)
   always_comb begin
      sum = (SUM_BITS+1)'(left_value_ff) + (SUM_BITS+1)'(upleft_value_ff)
          + (SUM_BITS+1)'(up.value) + (SUM_BITS+1)'(1)
          + (SUM_BITS+1)'(SUM_BIAS / 2);
      biased = sum[SUM_BITS-1:0];
      prod   = PROD_BITS'(biased) * PROD_BITS'(DIV3_MULT);
      quot   = prod[DIV3_SHIFT +: COEFF_BITS];
      // remove bias / 3, a half-range offset
      pred_avg = {~quot[COEFF_BITS-1], quot[COEFF_BITS-2:0]};
   end

   always_comb begin
      not_col0 = (pos.col != '0);
      if (pos.first_row) begin
         pred = not_col0 ? left_value_ff : '0;
      end else if (!not_col0) begin
         pred = up.value;
      end else begin
         pred = pred_avg;
      end

      resid = item.skipped ? '0 : item.residual_in;
      nz    = (resid != '0);
      total = (COEFF_BITS+1)'(resid) + (COEFF_BITS+1)'(pred);
      if (total[COEFF_BITS] != total[COEFF_BITS-1]) begin
         rec = {total[COEFF_BITS], {(COEFF_BITS-1){~total[COEFF_BITS]}}};
      end else begin
         rec = total[COEFF_BITS-1:0];
      end

      rsp.reconstructed         = rec;
      rsp.prediction_out        = pred;
      rsp.neighbourhood_nonzero = (!pos.first_row && up.nonzero)
                                | (not_col0 && left_nz_ff)
                                | (!pos.first_row && not_col0 && upleft_nz_ff);
      rsp.row_end               = pos.row_end;

      wr_entry.value   = rec;
      wr_entry.nonzero = nz;
   end

   always_comb begin
      left_value_in   = advance ? rec        : left_value_ff;
      left_nz_in      = advance ? nz         : left_nz_ff;
      upleft_value_in = advance ? up.value   : upleft_value_ff;
      upleft_nz_in    = advance ? up.nonzero : upleft_nz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_value_ff   <= '0;
         upleft_value_ff <= '0;
         left_nz_ff      <= 1'b0;
         upleft_nz_ff    <= 1'b0;
      end else begin
         left_value_ff   <= left_value_in;
         upleft_value_ff <= upleft_value_in;
         left_nz_ff      <= left_nz_in;
         upleft_nz_ff    <= upleft_nz_in;
      end
   end

endmodule : dcp_predictor
`default_nettype wire
